// ===== src/qtg_pkg.sv =====
// ----------------------------------------------------------------------------
// qtg_pkg
// Shared types and constants of the quadrature tone generator: CORDIC
// datapath widths, the arctangent table, the stage record and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package qtg_pkg;

  // datapath widths of the rotation chain
  localparam int XW = 34;
  localparam int ZW = 33;
  localparam int ANGLE_W = 32;
  localparam int OUT_W = 16;
  localparam int TABLE_LEN = 24;

  // CORDIC gain 0.60725293500888 in Q30
  localparam logic [29:0] GAIN_Q30 = 30'd652032874;

  // configuration port
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;
  localparam int STEP_W = 32;
  localparam int AMP_W = 15;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 1'b1;

  // atan(2^-i) with one turn = 2^32
  localparam logic signed [ZW-1:0] ATAN_TURN [TABLE_LEN] = '{
    33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
    33'sd42667331, 33'sd21354465, 33'sd10679838, 33'sd5340245,
    33'sd2670163, 33'sd1335086, 33'sd667544, 33'sd333772,
    33'sd166886, 33'sd83443, 33'sd41721, 33'sd20860,
    33'sd10430, 33'sd5215, 33'sd2607, 33'sd1303,
    33'sd651, 33'sd325, 33'sd162, 33'sd81
  };

  // one sample on its way through the rotation chain
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [1:0]           quad;
  } qtg_stage_t;

endpackage

`default_nettype wire

// ===== src/qtg_in_if.sv =====
// ----------------------------------------------------------------------------
// qtg_in_if
// Tick channel: one transaction requests one I/Q sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface qtg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

`default_nettype wire

// ===== src/qtg_out_if.sv =====
// ----------------------------------------------------------------------------
// qtg_out_if
// Sample channel: one transaction carries one I/Q pair.
// ----------------------------------------------------------------------------
`default_nettype none

interface qtg_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [qtg_pkg::OUT_W-1:0]   in_phase;
  logic signed [qtg_pkg::OUT_W-1:0]   quadrature;

  modport source (output valid, output in_phase, output quadrature, input ready);
  modport sink (input valid, input in_phase, input quadrature, output ready);
endinterface

`default_nettype wire

// ===== src/quadrature_tone_generator_unit.sv =====
// Each tick is registered in qtg_front, each CORDIC cell and the output register.
// One sample per cycle unless out_if stalls; every CORDIC stage is a cell with its
// own valid bit, so a stalled output only holds the cells that carry data.
// Reset (rst_n low, synchronous): phase accumulator, phase_step and amplitude
// cleared, all cells and the output register emptied.
// ----------------------------------------------------------------------------
// quadrature_tone_generator_unit
// Numerically controlled oscillator with I/Q output: phase accumulator,
// a chain of CORDIC cells and an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_tone_generator_unit #(
  parameter int PHASE_BITS    = 32,
  parameter int SAMPLE_BITS   = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [qtg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [qtg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  qtg_in_if.sink                                 in_if,
  qtg_out_if.source                              out_if
);
  import qtg_pkg::*;

  logic        chain_valid [CORDIC_STAGES+1];
  logic        chain_ready [CORDIC_STAGES+1];
  qtg_stage_t  chain_data  [CORDIC_STAGES+1];

  // phase accumulator and quadrant reduction
  qtg_front #(
    .PHASE_BITS (PHASE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_if.valid),
    .in_restart (in_if.restart),
    .in_ready   (in_if.ready),
    .dn_valid   (chain_valid[0]),
    .dn_ready   (chain_ready[0]),
    .dn_data    (chain_data[0])
  );

  // chain of rotation cells
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    qtg_cell #(
      .IDX (k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (chain_valid[k]),
      .up_ready (chain_ready[k]),
      .up_data  (chain_data[k]),
      .dn_valid (chain_valid[k+1]),
      .dn_ready (chain_ready[k+1]),
      .dn_data  (chain_data[k+1])
    );
  end

  // quadrant unfolding and output register
  qtg_out #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .up_valid       (chain_valid[CORDIC_STAGES]),
    .up_ready       (chain_ready[CORDIC_STAGES]),
    .up_data        (chain_data[CORDIC_STAGES]),
    .out_valid      (out_if.valid),
    .out_ready      (out_if.ready),
    .out_in_phase   (out_if.in_phase),
    .out_quadrature (out_if.quadrature)
  );

endmodule

`default_nettype wire

// ===== src/qtg_front.sv =====
// ----------------------------------------------------------------------------
// qtg_front
// Configuration registers, phase accumulator and quadrant reduction. Feeds
// the first record of the rotation chain with the scaled start vector.
// ----------------------------------------------------------------------------
`default_nettype none

module qtg_front #(
  parameter int PHASE_BITS = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [qtg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [qtg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                              in_valid,
  input  wire logic                              in_restart,
  output logic                                   in_ready,
  output logic                                   dn_valid,
  input  wire logic                              dn_ready,
  output qtg_pkg::qtg_stage_t                    dn_data
);
  import qtg_pkg::*;

  logic [STEP_W-1:0]         step_r;
  logic [AMP_W-1:0]          amp_r;
  logic [PHASE_BITS-1:0]     phase_acc_r;
  logic                      valid_r;
  qtg_stage_t                data_r;

  logic                      accept;
  logic [PHASE_BITS-1:0]     phase_cur;
  logic [PHASE_BITS-1:0]     step_ext;
  logic [63:0]               step_wide;
  logic [PHASE_BITS+31:0]    phase_wide;
  logic [ANGLE_W-1:0]        angle;
  logic [ANGLE_W-1:0]        angle_rnd;
  logic [1:0]                quad;
  logic [ANGLE_W-1:0]        resid;
  logic [44:0]               amp_prod;
  qtg_stage_t                data_nxt;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      amp_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PHASE_STEP: step_r <= cfg_wdata[STEP_W-1:0];
        REG_AMPLITUDE:  amp_r  <= cfg_wdata[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = !valid_r || dn_ready;
  assign accept   = in_valid && in_ready;

  // phase of this sample and the step fitted to the accumulator width
  assign phase_cur  = in_restart ? '0 : phase_acc_r;
  assign step_wide  = {32'd0, step_r};
  assign step_ext   = step_wide[PHASE_BITS-1:0];

  // top 32 bits of the phase, zero padded below a narrow phase
  assign phase_wide = {phase_cur, 32'd0};
  assign angle      = phase_wide[PHASE_BITS+31 -: ANGLE_W];

  // nearest quadrant and signed residual angle
  assign angle_rnd  = angle + 32'h2000_0000;
  assign quad       = angle_rnd[31:30];
  assign resid      = angle - {quad, 30'd0};

  // start vector: amplitude times CORDIC gain, Q16
  assign amp_prod   = 45'(amp_r) * 45'(GAIN_Q30);

  always_comb begin
    data_nxt.x    = signed'({{(XW-31){1'b0}}, amp_prod[44:14]});
    data_nxt.y    = '0;
    data_nxt.z    = signed'({{(ZW-ANGLE_W){resid[ANGLE_W-1]}}, resid});
    data_nxt.quad = quad;
  end

  // phase accumulator advances once per transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r <= '0;
      valid_r     <= 1'b0;
    end else begin
      if (accept) begin
        phase_acc_r <= phase_cur + step_ext;
      end
      if (in_ready) begin
        valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

// ===== src/qtg_cell.sv =====
// ----------------------------------------------------------------------------
// qtg_cell
// One CORDIC micro-rotation stage with its own valid bit; a bubble in this
// stage lets the upstream neighbour move on while downstream is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module qtg_cell #(
  parameter int IDX = 0
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 up_valid,
  output logic                      up_ready,
  input  wire qtg_pkg::qtg_stage_t  up_data,
  output logic                      dn_valid,
  input  wire logic                 dn_ready,
  output qtg_pkg::qtg_stage_t       dn_data
);
  import qtg_pkg::*;

  logic                  valid_r;
  qtg_stage_t            data_r;
  qtg_stage_t            data_nxt;
  logic signed [XW-1:0]  dx;
  logic signed [XW-1:0]  dy;

  assign up_ready = !valid_r || dn_ready;

  // rotate towards zero residual angle, floor shifts
  assign dx = up_data.y >>> IDX;
  assign dy = up_data.x >>> IDX;

  always_comb begin
    data_nxt = up_data;
    if (!up_data.z[ZW-1]) begin
      data_nxt.x = up_data.x - dx;
      data_nxt.y = up_data.y + dy;
      data_nxt.z = up_data.z - ATAN_TURN[IDX];
    end else begin
      data_nxt.x = up_data.x + dx;
      data_nxt.y = up_data.y - dy;
      data_nxt.z = up_data.z + ATAN_TURN[IDX];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

// ===== src/qtg_out.sv =====
// ----------------------------------------------------------------------------
// qtg_out
// Quadrant unfolding, truncation toward zero, saturation and the output
// register of the sample channel.
// ----------------------------------------------------------------------------
`default_nettype none

module qtg_out #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          up_valid,
  output logic                               up_ready,
  input  wire qtg_pkg::qtg_stage_t           up_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [qtg_pkg::OUT_W-1:0]   out_in_phase,
  output logic signed [qtg_pkg::OUT_W-1:0]   out_quadrature
);
  import qtg_pkg::*;

  localparam int RW = XW - 15;
  localparam logic signed [RW-1:0] SAT_HI = RW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);

  logic                     valid_r;
  logic signed [OUT_W-1:0]  i_r;
  logic signed [OUT_W-1:0]  q_r;
  logic signed [XW-1:0]     cos_v;
  logic signed [XW-1:0]     sin_v;
  logic signed [OUT_W-1:0]  i_nxt;
  logic signed [OUT_W-1:0]  q_nxt;

  // truncate a Q16 value toward zero and clamp to the sample range
  function automatic logic signed [OUT_W-1:0] trunc_sat(input logic signed [XW-1:0] v);
    logic signed [XW:0]   adj;
    logic signed [RW-1:0] r;
    adj = {v[XW-1], v} + (v[XW-1] ? (XW+1)'(17'h0FFFF) : '0);
    r   = RW'(adj >>> 16);
    if (r > SAT_HI) begin
      r = SAT_HI;
    end else if (r < SAT_LO) begin
      r = SAT_LO;
    end
    return r[OUT_W-1:0];
  endfunction

  // unfold the quadrant
  always_comb begin
    unique case (up_data.quad)
      2'd0: begin
        cos_v = up_data.x;
        sin_v = up_data.y;
      end
      2'd1: begin
        cos_v = -up_data.y;
        sin_v = up_data.x;
      end
      2'd2: begin
        cos_v = -up_data.x;
        sin_v = -up_data.y;
      end
      default: begin
        cos_v = up_data.y;
        sin_v = -up_data.x;
      end
    endcase
  end

  assign i_nxt    = trunc_sat(cos_v);
  assign q_nxt    = trunc_sat(sin_v);
  assign up_ready = !valid_r || out_ready;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      i_r <= i_nxt;
      q_r <= q_nxt;
    end
  end

  assign out_valid      = valid_r;
  assign out_in_phase   = i_r;
  assign out_quadrature = q_r;

endmodule

`default_nettype wire
